[rtl/core/mqtl_pkg.sv]
package mqtl_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int LEN_W = $clog2(SLOT_COUNT + 1);
  localparam int ID_W = 16;
  localparam int NQ = 3;

  localparam logic [1:0] Q_RUN  = 2'd0;
  localparam logic [1:0] Q_DEAD = 2'd1;
  localparam logic [1:0] Q_FORK = 2'd2;
  localparam logic [1:0] Q_BAD  = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH        = 3'd0,
    OP_POP         = 3'd1,
    OP_REMOVE_SLOT = 3'd2,
    OP_REMOVE_ID   = 3'd3,
    OP_ROTATE      = 3'd4,
    OP_MOVE_ALL    = 3'd5,
    OP_PEEK        = 3'd6,
    OP_NONE        = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_HEAD_RD,
    ST_HEAD_EV,
    ST_SCAN,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_MOVE_A,
    ST_MOVE_B,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [1:0]        queue_select;
    logic [1:0]        target_queue;
    logic [SLOT_W-1:0] task_handle;
    logic [ID_W-1:0]   task_id;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] result_handle;
    logic [ID_W-1:0]   result_id;
    logic [1:0]        found_queue;
    logic [LEN_W-1:0]  moved_count;
  } rsp_t;

endpackage

[rtl/core/mqtl_ram.sv]
module mqtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/multi_queue_task_list_manager.sv]
// Three circular linked task queues (run, dead, fork) over a shared pool of
// task slots; links and ids sit in two one-port-read RAMs. One command is
// worked at a time, the next is taken as soon as the sequencer is idle, even
// while the previous response still waits. Remove walks the links one slot
// at a time (RAM read, then compare) over the searched queues.
module multi_queue_task_list_manager (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  mqtl_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mqtl_pkg::rsp_t rsp
);

  localparam int SW = mqtl_pkg::SLOT_W;
  localparam int LW = mqtl_pkg::LEN_W;
  localparam int IW = mqtl_pkg::ID_W;

  mqtl_pkg::state_t state, state_next;
  mqtl_pkg::cmd_t   op_reg, op_reg_next;
  mqtl_pkg::rsp_t   res, res_next;
  mqtl_pkg::rsp_t   rsp_next;
  logic             rsp_valid_next;

  logic [SW-1:0] head [mqtl_pkg::NQ];
  logic [SW-1:0] head_next [mqtl_pkg::NQ];
  logic [SW-1:0] tail [mqtl_pkg::NQ];
  logic [SW-1:0] tail_next [mqtl_pkg::NQ];
  logic [LW-1:0] len [mqtl_pkg::NQ];
  logic [LW-1:0] len_next [mqtl_pkg::NQ];
  logic [mqtl_pkg::SLOT_COUNT-1:0] used, used_next;

  logic [SW-1:0] cur, cur_next, prev, prev_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [1:0]    wq, wq_next;

  logic          link_we, id_we, rd_en;
  logic [SW-1:0] link_waddr, id_waddr, rd_addr;
  logic [SW-1:0] link_wdata, link_rd;
  logic [IW-1:0] id_wdata, id_rd;

  mqtl_ram #(.WIDTH(SW), .DEPTH(mqtl_pkg::SLOT_COUNT)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(link_rd)
  );

  mqtl_ram #(.WIDTH(IW), .DEPTH(mqtl_pkg::SLOT_COUNT)) u_id (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .re(rd_en), .raddr(rd_addr), .rdata(id_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mqtl_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
      used      <= '0;
      for (int k = 0; k < mqtl_pkg::NQ; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
        len[k]  <= '0;
      end
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      used      <= used_next;
      for (int k = 0; k < mqtl_pkg::NQ; k++) begin
        head[k] <= head_next[k];
        tail[k] <= tail_next[k];
        len[k]  <= len_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_reg <= op_reg_next;
    res    <= res_next;
    rsp    <= rsp_next;
    cur    <= cur_next;
    prev   <= prev_next;
    cnt    <= cnt_next;
    wq     <= wq_next;
  end

  always_comb begin
    logic [1:0]    q, t;
    logic [SW-1:0] h;
    logic          hit;
    q = op_reg.queue_select;
    t = op_reg.target_queue;
    h = op_reg.task_handle;
    hit = 1'b0;

    state_next     = state;
    op_reg_next    = op_reg;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    used_next      = used;
    cur_next       = cur;
    prev_next      = prev;
    cnt_next       = cnt;
    wq_next        = wq;
    for (int k = 0; k < mqtl_pkg::NQ; k++) begin
      head_next[k] = head[k];
      tail_next[k] = tail[k];
      len_next[k]  = len[k];
    end
    cmd_ready  = 1'b0;
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    id_we      = 1'b0;
    id_waddr   = '0;
    id_wdata   = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;

    case (state)
      mqtl_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_reg_next = cmd;
          res_next    = '0;
          state_next  = mqtl_pkg::ST_OUT;
          case (cmd.operation)
            mqtl_pkg::OP_PUSH: begin
              if (cmd.queue_select != mqtl_pkg::Q_BAD && !used[cmd.task_handle]) begin
                state_next = mqtl_pkg::ST_PUSH_A;
              end
            end
            mqtl_pkg::OP_POP, mqtl_pkg::OP_ROTATE, mqtl_pkg::OP_PEEK: begin
              if (cmd.queue_select != mqtl_pkg::Q_BAD &&
                  len[cmd.queue_select] != '0) begin
                state_next = mqtl_pkg::ST_HEAD_RD;
              end
            end
            mqtl_pkg::OP_REMOVE_SLOT: begin
              if (cmd.queue_select != mqtl_pkg::Q_BAD) begin
                wq_next    = cmd.queue_select;
                state_next = mqtl_pkg::ST_SCAN;
              end
            end
            mqtl_pkg::OP_REMOVE_ID: begin
              wq_next    = mqtl_pkg::Q_RUN;
              state_next = mqtl_pkg::ST_SCAN;
            end
            mqtl_pkg::OP_MOVE_ALL: begin
              if (cmd.queue_select != mqtl_pkg::Q_BAD &&
                  cmd.target_queue != mqtl_pkg::Q_BAD &&
                  cmd.queue_select != cmd.target_queue &&
                  len[cmd.queue_select] != '0) begin
                state_next = mqtl_pkg::ST_MOVE_A;
              end
            end
            default: ;
          endcase
        end
      end

      mqtl_pkg::ST_PUSH_A: begin
        id_we    = 1'b1;
        id_waddr = h;
        id_wdata = op_reg.task_id;
        res_next = '{found: 1'b1, result_handle: h, result_id: op_reg.task_id,
                     found_queue: q, moved_count: '0};
        if (len[q] == '0) begin
          link_we      = 1'b1;
          link_waddr   = h;
          link_wdata   = h;
          head_next[q] = h;
          tail_next[q] = h;
          len_next[q]  = LW'(1);
          used_next[h] = 1'b1;
          state_next   = mqtl_pkg::ST_OUT;
        end else begin
          link_we    = 1'b1;
          link_waddr = tail[q];
          link_wdata = h;
          state_next = mqtl_pkg::ST_PUSH_B;
        end
      end

      mqtl_pkg::ST_PUSH_B: begin
        link_we      = 1'b1;
        link_waddr   = h;
        link_wdata   = head[q];
        tail_next[q] = h;
        len_next[q]  = len[q] + LW'(1);
        used_next[h] = 1'b1;
        state_next   = mqtl_pkg::ST_OUT;
      end

      mqtl_pkg::ST_HEAD_RD: begin
        rd_en      = 1'b1;
        rd_addr    = head[q];
        state_next = mqtl_pkg::ST_HEAD_EV;
      end

      mqtl_pkg::ST_HEAD_EV: begin
        res_next = '{found: 1'b1, result_handle: head[q], result_id: id_rd,
                     found_queue: q, moved_count: '0};
        if (op_reg.operation == mqtl_pkg::OP_POP) begin
          used_next[head[q]] = 1'b0;
          if (len[q] == LW'(1)) begin
            head_next[q] = '0;
            tail_next[q] = '0;
            len_next[q]  = '0;
          end else begin
            link_we      = 1'b1;
            link_waddr   = tail[q];
            link_wdata   = link_rd;
            head_next[q] = link_rd;
            len_next[q]  = len[q] - LW'(1);
          end
        end else if (op_reg.operation == mqtl_pkg::OP_ROTATE) begin
          tail_next[q] = head[q];
          head_next[q] = link_rd;
        end
        state_next = mqtl_pkg::ST_OUT;
      end

      mqtl_pkg::ST_SCAN: begin
        if (len[wq] == '0) begin
          if (op_reg.operation == mqtl_pkg::OP_REMOVE_ID && wq != mqtl_pkg::Q_DEAD) begin
            wq_next = (wq == mqtl_pkg::Q_RUN) ? mqtl_pkg::Q_FORK : mqtl_pkg::Q_DEAD;
          end else begin
            state_next = mqtl_pkg::ST_OUT;
          end
        end else begin
          prev_next  = tail[wq];
          cur_next   = head[wq];
          cnt_next   = '0;
          state_next = mqtl_pkg::ST_WALK_RD;
        end
      end

      mqtl_pkg::ST_WALK_RD: begin
        rd_en      = 1'b1;
        rd_addr    = cur;
        state_next = mqtl_pkg::ST_WALK_EV;
      end

      mqtl_pkg::ST_WALK_EV: begin
        hit = (op_reg.operation == mqtl_pkg::OP_REMOVE_ID) ? (id_rd == op_reg.task_id)
                                                           : (cur == h);
        if (hit) begin
          res_next = '{found: 1'b1, result_handle: cur, result_id: id_rd,
                       found_queue: wq, moved_count: '0};
          used_next[cur] = 1'b0;
          if (len[wq] <= LW'(1)) begin
            head_next[wq] = '0;
            tail_next[wq] = '0;
            len_next[wq]  = '0;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev;
            link_wdata = link_rd;
            if (cur == tail[wq]) tail_next[wq] = prev;
            if (cur == head[wq]) head_next[wq] = link_rd;
            len_next[wq] = len[wq] - LW'(1);
          end
          state_next = mqtl_pkg::ST_OUT;
        end else if (cnt + LW'(1) == len[wq]) begin
          if (op_reg.operation == mqtl_pkg::OP_REMOVE_ID && wq != mqtl_pkg::Q_DEAD) begin
            wq_next    = (wq == mqtl_pkg::Q_RUN) ? mqtl_pkg::Q_FORK : mqtl_pkg::Q_DEAD;
            state_next = mqtl_pkg::ST_SCAN;
          end else begin
            state_next = mqtl_pkg::ST_OUT;
          end
        end else begin
          prev_next  = cur;
          cur_next   = link_rd;
          cnt_next   = cnt + LW'(1);
          state_next = mqtl_pkg::ST_WALK_RD;
        end
      end

      mqtl_pkg::ST_MOVE_A: begin
        res_next.moved_count = len[q];
        head_next[q] = '0;
        tail_next[q] = '0;
        len_next[q]  = '0;
        if (len[t] == '0) begin
          head_next[t] = head[q];
          tail_next[t] = tail[q];
          len_next[t]  = len[q];
          state_next   = mqtl_pkg::ST_OUT;
        end else begin
          // source state held until the second splice write
          head_next[q] = head[q];
          tail_next[q] = tail[q];
          len_next[q]  = len[q];
          link_we      = 1'b1;
          link_waddr   = tail[t];
          link_wdata   = head[q];
          state_next   = mqtl_pkg::ST_MOVE_B;
        end
      end

      mqtl_pkg::ST_MOVE_B: begin
        link_we      = 1'b1;
        link_waddr   = tail[q];
        link_wdata   = head[t];
        tail_next[t] = tail[q];
        len_next[t]  = len[t] + len[q];
        head_next[q] = '0;
        tail_next[q] = '0;
        len_next[q]  = '0;
        state_next   = mqtl_pkg::ST_OUT;
      end

      mqtl_pkg::ST_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = mqtl_pkg::ST_IDLE;
        end
      end

      default: state_next = mqtl_pkg::ST_IDLE;
    endcase
  end

endmodule
